[rtl/kpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared types and event codes for the key path tokenizer.
// ----------------------------------------------------------------------------
package kpt_pkg;

	localparam logic [2:0] EV_KEY_BYTE = 3'd0;
	localparam logic [2:0] EV_KEY_END  = 3'd1;
	localparam logic [2:0] EV_INDEX    = 3'd2;
	localparam logic [2:0] EV_ERROR    = 3'd3;
	localparam logic [2:0] EV_DONE     = 3'd4;

	localparam logic [2:0] FAULT_TRAIL_BSL   = 3'd0;
	localparam logic [2:0] FAULT_DOLLAR      = 3'd1;
	localparam logic [2:0] FAULT_AFTER_DOL   = 3'd2;
	localparam logic [2:0] FAULT_NO_BRACKET  = 3'd3;
	localparam logic [2:0] FAULT_BAD_INDEX   = 3'd4;
	localparam logic [2:0] FAULT_BAD_COMP    = 3'd5;

	localparam int unsigned MAX_EVENTS = 3;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         key_char;
		logic signed [31:0] index_value;
		logic [2:0]         fault;
		logic               eor;
	} event_t;

	// Events caused by one byte, slot 0 first
	typedef struct packed {
		logic [1:0]                  count;
		event_t [MAX_EVENTS-1:0]     ev;
	} bundle_t;

endpackage

[rtl/kpt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpt_front
// Accepts path bytes, tracks the parse state and packs the events that each
// byte causes into one bundle.
// ----------------------------------------------------------------------------
module kpt_front
	import kpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  path_byte,
	input  logic        final_byte,
	input  logic        dollar_allowed,
	output logic        push_valid,
	input  logic        push_ready,
	output bundle_t     push_data
);

	localparam logic [2:0] PH_FIRST         = 3'd0;
	localparam logic [2:0] PH_AFTER_DOLLAR  = 3'd1;
	localparam logic [2:0] PH_KEY           = 3'd2;
	localparam logic [2:0] PH_BRACKET       = 3'd3;
	localparam logic [2:0] PH_AFTER_BRACKET = 3'd4;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LBR    = 8'h5B;
	localparam logic [7:0] CH_RBR    = 8'h5D;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;

	localparam logic [31:0] MAG_POS_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] MAG_NEG_MAX  = 32'h8000_0000;
	localparam logic [31:0] MAG_PRE_MAX  = 32'd214748364;

	logic [2:0]  phase_q, phase_d;
	logic        key_open_q, key_open_d;
	logic        esc_q, esc_d;
	logic        neg_q, neg_d;
	logic [31:0] mag_q, mag_d;
	logic        has_digit_q, has_digit_d;
	logic        invalid_q, invalid_d;
	logic        halted_q, halted_d;

	logic        accept;
	bundle_t     bnd;
	logic [2:0]  n_ev;

	function automatic event_t mk_ev(logic [2:0] kind, logic [7:0] ch, logic [31:0] idx,
		logic [2:0] fault, logic eor);
		event_t e;
		e.kind        = kind;
		e.key_char    = ch;
		e.index_value = idx;
		e.fault       = fault;
		e.eor         = eor;
		return e;
	endfunction

	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = accept && (n_ev != 3'd0);
	assign push_data  = bnd;

	always_comb begin
		logic        is_delim;
		logic        fail_now;
		logic [2:0]  fail_code;
		logic        open_now;
		logic [35:0] prod;
		logic        idx_ok;
		logic [31:0] idx_v;

		phase_d     = phase_q;
		key_open_d  = key_open_q;
		esc_d       = esc_q;
		neg_d       = neg_q;
		mag_d       = mag_q;
		has_digit_d = has_digit_q;
		invalid_d   = invalid_q;
		halted_d    = halted_q;
		bnd         = '0;
		n_ev        = 3'd0;
		fail_now    = 1'b0;
		fail_code   = FAULT_TRAIL_BSL;
		open_now    = 1'b0;

		is_delim = (path_byte == CH_DOT) || (path_byte == CH_LBR);
		prod     = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {32'd0, path_byte[3:0]};
		idx_ok   = has_digit_q && !invalid_q &&
			(neg_q ? (mag_q <= MAG_NEG_MAX) : (mag_q <= MAG_POS_MAX));
		idx_v    = neg_q ? (32'd0 - mag_q) : mag_q;

		if (halted_q) begin
			// drop bytes up to the end of the failed specifier
			if (final_byte) begin
				halted_d = 1'b0;
			end
		end else begin
			if (final_byte && (path_byte == CH_BSL)) begin
				fail_now  = 1'b1;
				fail_code = FAULT_TRAIL_BSL;
			end else begin
				case (phase_q)
					PH_AFTER_DOLLAR: begin
						if (is_delim) begin
							open_now = 1'b1;
						end else begin
							fail_now  = 1'b1;
							fail_code = FAULT_AFTER_DOL;
						end
					end
					PH_KEY: begin
						if (esc_q) begin
							esc_d      = 1'b0;
							key_open_d = 1'b1;
							bnd.ev[n_ev[1:0]] = mk_ev(EV_KEY_BYTE, path_byte, 32'd0,
								FAULT_TRAIL_BSL, 1'b0);
							n_ev = n_ev + 3'd1;
						end else if (path_byte == CH_BSL) begin
							esc_d = 1'b1;
						end else if (is_delim) begin
							if (key_open_q) begin
								bnd.ev[n_ev[1:0]] = mk_ev(EV_KEY_END, 8'd0, 32'd0,
									FAULT_TRAIL_BSL, 1'b0);
								n_ev = n_ev + 3'd1;
							end
							open_now = 1'b1;
						end else begin
							key_open_d = 1'b1;
							bnd.ev[n_ev[1:0]] = mk_ev(EV_KEY_BYTE, path_byte, 32'd0,
								FAULT_TRAIL_BSL, 1'b0);
							n_ev = n_ev + 3'd1;
						end
					end
					PH_BRACKET: begin
						if (path_byte == CH_RBR) begin
							if (!idx_ok) begin
								fail_now  = 1'b1;
								fail_code = FAULT_BAD_INDEX;
							end else begin
								bnd.ev[n_ev[1:0]] = mk_ev(EV_INDEX, 8'd0, idx_v,
									FAULT_TRAIL_BSL, 1'b0);
								n_ev        = n_ev + 3'd1;
								neg_d       = 1'b0;
								mag_d       = '0;
								has_digit_d = 1'b0;
								invalid_d   = 1'b0;
								phase_d     = PH_AFTER_BRACKET;
							end
						end else if ((path_byte == CH_MINUS) && !neg_q && !has_digit_q &&
							!invalid_q) begin
							neg_d = 1'b1;
						end else if (path_byte inside {[8'h30:8'h39]}) begin
							has_digit_d = 1'b1;
							if (!invalid_q) begin
								if ((mag_q > MAG_PRE_MAX) || (prod > {4'd0, MAG_NEG_MAX})) begin
									invalid_d = 1'b1;
								end else begin
									mag_d = prod[31:0];
								end
							end
						end else begin
							invalid_d = 1'b1;
						end
					end
					PH_AFTER_BRACKET: begin
						if (is_delim) begin
							open_now = 1'b1;
						end else begin
							fail_now  = 1'b1;
							fail_code = FAULT_BAD_COMP;
						end
					end
					default: begin
						// first byte: index state is already clear here
						if (path_byte == CH_DOLLAR) begin
							if (!dollar_allowed) begin
								fail_now  = 1'b1;
								fail_code = FAULT_DOLLAR;
							end else begin
								phase_d = PH_AFTER_DOLLAR;
							end
						end else if (is_delim) begin
							open_now = 1'b1;
						end else if (path_byte == CH_BSL) begin
							phase_d    = PH_KEY;
							key_open_d = 1'b0;
							esc_d      = 1'b1;
						end else begin
							phase_d    = PH_KEY;
							key_open_d = 1'b1;
							esc_d      = 1'b0;
							bnd.ev[n_ev[1:0]] = mk_ev(EV_KEY_BYTE, path_byte, 32'd0,
								FAULT_TRAIL_BSL, 1'b0);
							n_ev = n_ev + 3'd1;
						end
					end
				endcase
			end

			if (open_now) begin
				key_open_d  = 1'b0;
				esc_d       = 1'b0;
				neg_d       = 1'b0;
				mag_d       = '0;
				has_digit_d = 1'b0;
				invalid_d   = 1'b0;
				phase_d     = (path_byte == CH_LBR) ? PH_BRACKET : PH_KEY;
			end

			if (!fail_now && final_byte && (phase_d == PH_BRACKET)) begin
				fail_now  = 1'b1;
				fail_code = FAULT_NO_BRACKET;
			end

			if (fail_now) begin
				bnd.ev[n_ev[1:0]] = mk_ev(EV_ERROR, 8'd0, 32'd0, fail_code, 1'b1);
				n_ev = n_ev + 3'd1;
			end else if (final_byte) begin
				if ((phase_d == PH_KEY) && key_open_d) begin
					bnd.ev[n_ev[1:0]] = mk_ev(EV_KEY_END, 8'd0, 32'd0, FAULT_TRAIL_BSL, 1'b0);
					n_ev = n_ev + 3'd1;
				end
				bnd.ev[n_ev[1:0]] = mk_ev(EV_DONE, 8'd0, 32'd0, FAULT_TRAIL_BSL, 1'b1);
				n_ev = n_ev + 3'd1;
			end

			if (fail_now || final_byte) begin
				phase_d     = PH_FIRST;
				key_open_d  = 1'b0;
				esc_d       = 1'b0;
				neg_d       = 1'b0;
				mag_d       = '0;
				has_digit_d = 1'b0;
				invalid_d   = 1'b0;
				halted_d    = fail_now && !final_byte;
			end
		end

		bnd.count = n_ev[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			key_open_q  <= 1'b0;
			esc_q       <= 1'b0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			has_digit_q <= 1'b0;
			invalid_q   <= 1'b0;
			halted_q    <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			key_open_q  <= key_open_d;
			esc_q       <= esc_d;
			neg_q       <= neg_d;
			mag_q       <= mag_d;
			has_digit_q <= has_digit_d;
			invalid_q   <= invalid_d;
			halted_q    <= halted_d;
		end
	end

endmodule

[rtl/kpt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpt_queue
// Small FIFO of event bundles between the front and back halves.
// ----------------------------------------------------------------------------
module kpt_queue
	import kpt_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  bundle_t push_data,
	output logic    pop_valid,
	input  logic    pop_ready,
	output bundle_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bundle_t       mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[rtl/kpt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpt_back
// Unpacks event bundles and presents one registered result per transfer.
// ----------------------------------------------------------------------------
module kpt_back
	import kpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  bundle_t            pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         event_kind,
	output logic [7:0]         key_char,
	output logic signed [31:0] index_value,
	output logic [2:0]         fault_code,
	output logic               end_of_run
);

	bundle_t    cur_q;
	logic [1:0] sel_q;
	logic       busy_q;
	logic       take, last;
	event_t     ev;

	assign ev          = cur_q.ev[sel_q];
	assign out_valid   = busy_q;
	assign event_kind  = ev.kind;
	assign key_char    = ev.key_char;
	assign index_value = ev.index_value;
	assign fault_code  = ev.fault;
	assign end_of_run  = ev.eor;

	assign take      = out_valid && out_ready;
	assign last      = (sel_q == (cur_q.count - 2'd1));
	assign pop_ready = !busy_q || (take && last);

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= '0;
			busy_q <= 1'b0;
		end else if (pop_valid && pop_ready) begin
			sel_q  <= '0;
			busy_q <= 1'b1;
		end else if (take && last) begin
			busy_q <= 1'b0;
		end else if (take) begin
			// advance to the next event of the bundle
			sel_q <= sel_q + 2'd1;
		end
	end

endmodule

[rtl/key_path_tokenizer_unit.sv]
`timescale 1ns / 1ps
// Path: a byte's bundle is written into the bundle queue, then loaded into the
// output stage's register, which presents its first result.
// Throughput: one byte per cycle while out_ready is high and each byte yields at
// most one result; the output stage sends one result per cycle and keeps a bundle until all are taken.
// The bundle queue (QUEUE_DEPTH entries) lets the front keep taking bytes meanwhile.
// Reset: asynchronous, clears parse state, queue pointers and output valid.
// ----------------------------------------------------------------------------
// key_path_tokenizer_unit
// Splits a key path specifier, one byte per transfer, into key bytes, key
// ends, array indexes, errors and a done marker.
// ----------------------------------------------------------------------------
module key_path_tokenizer_unit
	import kpt_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         path_byte,
	input  logic               final_byte,
	input  logic               dollar_allowed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         event_kind,
	output logic [7:0]         key_char,
	output logic signed [31:0] index_value,
	output logic [2:0]         fault_code,
	output logic               end_of_run
);

	logic    push_valid, push_ready;
	bundle_t push_data;
	logic    pop_valid, pop_ready;
	bundle_t pop_data;

	kpt_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.path_byte      (path_byte),
		.final_byte     (final_byte),
		.dollar_allowed (dollar_allowed),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_data      (push_data)
	);

	kpt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	kpt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_kind  (event_kind),
		.key_char    (key_char),
		.index_value (index_value),
		.fault_code  (fault_code),
		.end_of_run  (end_of_run)
	);

endmodule
